[sv/ethp_pkg.sv]
// Shared types and constants for the Ethernet/IPv4/TCP header parser.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package ethp_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 65536;
   localparam int unsigned ETH_HDR_LEN     = 14;
   localparam int unsigned TCP_MIN_LEN     = 20;
   localparam int unsigned IHL_MIN         = 5;
   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam int unsigned QUEUE_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CSR_ADDR_W      = 1;
   localparam int unsigned CSR_DATA_W      = 16;
   localparam int unsigned RSP_DATA_W      = 216;

   localparam logic [16:0] OFFSET_LIMIT    = 17'(MAX_FRAME_BYTES);
   localparam logic [15:0] OFFSET_MAX      = 16'hFFFF;
   localparam logic [15:0] RESET_ETHERTYPE = 16'h0800;
   localparam logic [7:0]  RESET_PROTOCOL  = 8'h06;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MATCH_ETHERTYPE = 1'b0,
      CSR_MATCH_PROTOCOL  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] total_len;
      logic [3:0]  ip_hdr_words;
      logic [3:0]  tcp_hdr_words;
      logic [7:0]  tcp_flag_bits;
      logic [15:0] dst_port;
      logic [15:0] src_port;
      logic [31:0] dst_ip;
      logic [31:0] src_ip;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
   } hdr_summary_type;

endpackage

`default_nettype wire

[sv/ethp_front.sv]
// Front part of the header parser: takes frame bytes, tracks the byte offset,
// captures header fields and decides at the last byte whether a summary is due.
// Depends on ethp_pkg.
`default_nettype none

module ethp_front (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [7:0]                     req_tdata,
   input  wire                            req_tlast,
   input  wire                            csr_we,
   input  wire  [ethp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire  [ethp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire                            q_full,
   output logic                           push,
   output ethp_pkg::hdr_summary_type      push_data
);
   import ethp_pkg::*;

   logic [15:0] offset_ff, offset_in;
   logic [15:0] match_eth_ff, match_eth_in;
   logic [7:0]  match_proto_ff, match_proto_in;

   logic [47:0] dst_mac_ff, dst_mac_in;
   logic [47:0] src_mac_ff, src_mac_in;
   logic [15:0] eth_ff, eth_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ip_ff, src_ip_in;
   logic [31:0] dst_ip_ff, dst_ip_in;
   logic [15:0] src_port_ff, src_port_in;
   logic [15:0] dst_port_ff, dst_port_in;
   logic [3:0]  thw_ff, thw_in;
   logic [7:0]  flags_ff, flags_in;

   logic        accept;
   logic        in_range;
   logic [6:0]  tcp_start;
   logic [15:0] tcp_off;
   logic [6:0]  need_m1;
   logic        frame_ok;
   csr_index_type csr_index;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign in_range   = {1'b0, offset_ff} < OFFSET_LIMIT;
   assign tcp_start  = 7'(ETH_HDR_LEN) + {1'b0, ihl_ff, 2'b00};
   assign tcp_off    = offset_ff - {9'b0, tcp_start};
   assign csr_index  = csr_index_type'(csr_addr);

   always_comb begin
      dst_mac_in  = dst_mac_ff;
      src_mac_in  = src_mac_ff;
      eth_in      = eth_ff;
      ihl_in      = ihl_ff;
      total_in    = total_ff;
      proto_in    = proto_ff;
      src_ip_in   = src_ip_ff;
      dst_ip_in   = dst_ip_ff;
      src_port_in = src_port_ff;
      dst_port_in = dst_port_ff;
      thw_in      = thw_ff;
      flags_in    = flags_ff;
      if (in_range) begin
         if (offset_ff < 16'd6) begin
            dst_mac_in = {dst_mac_ff[39:0], req_tdata};
         end else if (offset_ff < 16'd12) begin
            src_mac_in = {src_mac_ff[39:0], req_tdata};
         end else if (offset_ff < 16'd14) begin
            eth_in = {eth_ff[7:0], req_tdata};
         end else if (offset_ff == 16'd14) begin
            ihl_in = req_tdata[3:0];
         end else if (offset_ff == 16'd16 || offset_ff == 16'd17) begin
            total_in = {total_ff[7:0], req_tdata};
         end else if (offset_ff == 16'd23) begin
            proto_in = req_tdata;
         end else if (offset_ff >= 16'd26 && offset_ff < 16'd30) begin
            src_ip_in = {src_ip_ff[23:0], req_tdata};
         end else if (offset_ff >= 16'd30 && offset_ff < 16'd34) begin
            dst_ip_in = {dst_ip_ff[23:0], req_tdata};
         end
         // The TCP header begins right after the IPv4 header.
         if (ihl_in >= 4'(IHL_MIN) && offset_ff >= {9'b0, tcp_start}) begin
            if (tcp_off < 16'd2) begin
               src_port_in = {src_port_ff[7:0], req_tdata};
            end else if (tcp_off < 16'd4) begin
               dst_port_in = {dst_port_ff[7:0], req_tdata};
            end else if (tcp_off == 16'd12) begin
               thw_in = req_tdata[7:4];
            end else if (tcp_off == 16'd13) begin
               flags_in = req_tdata;
            end
         end
      end
   end

   always_comb begin
      need_m1  = 7'(ETH_HDR_LEN + TCP_MIN_LEN - 1) + {1'b0, ihl_in, 2'b00};
      frame_ok = (ihl_in >= 4'(IHL_MIN))
               && (offset_ff >= {9'b0, need_m1})
               && ({10'b0, need_m1} < OFFSET_LIMIT)
               && (eth_in == match_eth_ff)
               && (proto_in == match_proto_ff);
   end

   assign push = accept && req_tlast && frame_ok;

   always_comb begin
      push_data.total_len     = total_in;
      push_data.ip_hdr_words  = ihl_in;
      push_data.tcp_hdr_words = thw_in;
      push_data.tcp_flag_bits = flags_in;
      push_data.dst_port      = dst_port_in;
      push_data.src_port      = src_port_in;
      push_data.dst_ip        = dst_ip_in;
      push_data.src_ip        = src_ip_in;
      push_data.src_mac       = src_mac_in;
      push_data.dst_mac       = dst_mac_in;
   end

   always_comb begin
      offset_in = offset_ff;
      if (accept) begin
         if (req_tlast) begin
            offset_in = '0;
         end else if (offset_ff != OFFSET_MAX) begin
            offset_in = offset_ff + 16'd1;
         end
      end
   end

   always_comb begin
      match_eth_in   = match_eth_ff;
      match_proto_in = match_proto_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MATCH_ETHERTYPE: match_eth_in = csr_wdata[15:0];
            CSR_MATCH_PROTOCOL:  match_proto_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff      <= '0;
         match_eth_ff   <= RESET_ETHERTYPE;
         match_proto_ff <= RESET_PROTOCOL;
      end else begin
         offset_ff      <= offset_in;
         match_eth_ff   <= match_eth_in;
         match_proto_ff <= match_proto_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ihl_ff <= '0;
      end else if (accept) begin
         ihl_ff <= ihl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dst_mac_ff  <= dst_mac_in;
         src_mac_ff  <= src_mac_in;
         eth_ff      <= eth_in;
         total_ff    <= total_in;
         proto_ff    <= proto_in;
         src_ip_ff   <= src_ip_in;
         dst_ip_ff   <= dst_ip_in;
         src_port_ff <= src_port_in;
         dst_port_ff <= dst_port_in;
         thw_ff      <= thw_in;
         flags_ff    <= flags_in;
      end
   end

   a_offset_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (offset_ff == '0))
      else $error("byte offset did not restart after the last item of a frame");

endmodule

`default_nettype wire

[sv/ethp_queue.sv]
// Short queue of header summaries between the front and back parts.
// Depends on ethp_pkg.
`default_nettype none

module ethp_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  ethp_pkg::hdr_summary_type push_data,
   input  wire                       pop,
   output logic                      full,
   output logic                      not_empty,
   output ethp_pkg::hdr_summary_type head_data
);
   import ethp_pkg::*;

   hdr_summary_type entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("summary written into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("summary taken from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond its depth");

endmodule

`default_nettype wire

[sv/ethp_back.sv]
// Back part of the header parser: takes summaries from the queue, works out the
// payload length and holds the result item in an output register.
// Depends on ethp_pkg.
`default_nettype none

module ethp_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 q_not_empty,
   input  ethp_pkg::hdr_summary_type           q_head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [ethp_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import ethp_pkg::*;

   logic                  valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff;
   logic [RSP_DATA_W-1:0] data_in;
   logic [6:0]            hdr_bytes;
   logic [16:0]           payload_diff;
   logic [15:0]           payload;

   assign pop = q_not_empty && (!valid_ff || rsp_tready);

   always_comb begin
      hdr_bytes    = {1'b0, q_head.ip_hdr_words, 2'b00} + {1'b0, q_head.tcp_hdr_words, 2'b00};
      payload_diff = {1'b0, q_head.total_len} - {10'b0, hdr_bytes};
      payload      = payload_diff[16] ? '0 : payload_diff[15:0];
      data_in      = {payload, q_head.tcp_flag_bits, q_head.dst_port, q_head.src_port,
                      q_head.dst_ip, q_head.src_ip, q_head.src_mac, q_head.dst_mac};
      valid_in     = pop || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("summary left the queue but no result item was loaded");

endmodule

`default_nettype wire

[sv/eth_ipv4_tcp_header_parser_unit.sv]
// Ethernet/IPv4/TCP header parser: takes one frame byte per cycle while the summary
// queue is not full and gives one summary per matching, complete frame. The result
// item is written into the summary queue and then into the output register. Bytes
// are held back while the queue is full; a two-entry summary queue and the output
// register absorb result stalls. Reset is synchronous and active high: it clears
// the offset, queue and output valid, and loads EtherType 0x0800 and protocol 6.
`default_nettype none

module eth_ipv4_tcp_header_parser_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [7:0]                           req_tdata,  // frame_byte
   input  wire                                  req_tlast,  // is_last
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // dst_mac, src_mac, src_ip, dst_ip, src_port, dst_port, tcp_flag_bits, payload_bytes
   output logic [ethp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire                                  csr_we,
   input  wire  [ethp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [ethp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ethp_pkg::*;

   logic            push;
   logic            pop;
   logic            q_full;
   logic            q_not_empty;
   hdr_summary_type push_data;
   hdr_summary_type q_head;

   ethp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .push       (push),
      .push_data  (push_data)
   );

   ethp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   ethp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

[verif/tb_eth_ipv4_tcp_header_parser_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Ethernet/IPv4/TCP header parser unit.
// Frames are sent byte by byte, a shadow parser predicts each header summary and the
// result stream is checked against it; depends on ethp_pkg and the parser RTL.

module tb_eth_ipv4_tcp_header_parser_unit;
   import ethp_pkg::*;

   localparam int STALL_CYCLES     = 500;
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_FRAME_BYTES = 65600;
   localparam int MAX_PRINTS       = 50;

   typedef struct packed {
      logic [47:0] dmac;
      logic [47:0] smac;
      logic [15:0] etype;
      logic [3:0]  ihl;
      logic [15:0] total;
      logic [7:0]  proto;
      logic [31:0] sip;
      logic [31:0] dip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [3:0]  doff;
      logic [7:0]  flags;
   } frame_fields_t;

   // Same layout as rsp_tdata: the destination MAC sits in the lowest bits.
   typedef struct packed {
      logic [15:0] payload;
      logic [7:0]  flags;
      logic [15:0] dport;
      logic [15:0] sport;
      logic [31:0] dip;
      logic [31:0] sip;
      logic [47:0] smac;
      logic [47:0] dmac;
   } summary_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire  [RSP_DATA_W-1:0] rsp_tdata;

   eth_ipv4_tcp_header_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the parser state and its match registers.
   logic [15:0] cfg_etype = RESET_ETHERTYPE;
   logic [7:0]  cfg_proto = RESET_PROTOCOL;
   logic [15:0] seen_offset = '0;
   logic [47:0] seen_dmac = '0;
   logic [47:0] seen_smac = '0;
   logic [15:0] seen_etype = '0;
   logic [3:0]  seen_ihl = '0;
   logic [15:0] seen_total = '0;
   logic [7:0]  seen_proto = '0;
   logic [31:0] seen_sip = '0;
   logic [31:0] seen_dip = '0;
   logic [15:0] seen_sport = '0;
   logic [15:0] seen_dport = '0;
   logic [3:0]  seen_doff = '0;
   logic [7:0]  seen_flags = '0;

   summary_t    pending_summaries[$];
   logic [7:0]  frame_bytes[$];
   int          error_count = 0;
   int          summaries_expected = 0;
   int          summaries_checked = 0;
   int          frames_sent = 0;
   int          bytes_sent = 0;
   int          send_idle_pct = 19;
   int          recv_idle_pct = 85;
   int          stall_requests = 0;

   task automatic flag_error(input string msg);
      if (error_count < MAX_PRINTS)
         $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         flag_error($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // Captures one frame byte and, on the last byte of a complete matching frame,
   // queues the header summary the block should give.
   task automatic parse_frame_byte(input logic [7:0] b, input logic last);
      int unsigned pos, tcp_start, t, count;
      int          payload;
      summary_t    s;
      pos = seen_offset;
      if (pos < MAX_FRAME_BYTES) begin
         // The TCP start uses the header length held before this byte.
         tcp_start = ETH_HDR_LEN + 4 * seen_ihl;
         if (pos < 6) seen_dmac = {seen_dmac[39:0], b};
         else if (pos < 12) seen_smac = {seen_smac[39:0], b};
         else if (pos < 14) seen_etype = {seen_etype[7:0], b};
         else if (pos == 14) seen_ihl = b[3:0];
         else if (pos == 16 || pos == 17) seen_total = {seen_total[7:0], b};
         else if (pos == 23) seen_proto = b;
         else if (pos >= 26 && pos < 30) seen_sip = {seen_sip[23:0], b};
         else if (pos >= 30 && pos < 34) seen_dip = {seen_dip[23:0], b};
         if (seen_ihl >= IHL_MIN && pos >= tcp_start) begin
            t = pos - tcp_start;
            if (t < 2) seen_sport = {seen_sport[7:0], b};
            else if (t < 4) seen_dport = {seen_dport[7:0], b};
            else if (t == 12) seen_doff = b[7:4];
            else if (t == 13) seen_flags = b;
         end
      end
      if (!last) begin
         if (seen_offset != OFFSET_MAX) seen_offset++;
      end else begin
         seen_offset = '0;
         count = pos + 1;
         if (count > MAX_FRAME_BYTES) count = MAX_FRAME_BYTES;
         if (count >= ETH_HDR_LEN + 1 && seen_ihl >= IHL_MIN &&
             count >= ETH_HDR_LEN + 4 * seen_ihl + TCP_MIN_LEN &&
             seen_etype == cfg_etype && seen_proto == cfg_proto) begin
            payload = int'(seen_total) - 4 * int'(seen_ihl) - 4 * int'(seen_doff);
            if (payload < 0) payload = 0;
            s.dmac    = seen_dmac;
            s.smac    = seen_smac;
            s.sip     = seen_sip;
            s.dip     = seen_dip;
            s.sport   = seen_sport;
            s.dport   = seen_dport;
            s.flags   = seen_flags;
            s.payload = payload[15:0];
            pending_summaries.push_back(s);
            summaries_expected++;
         end
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_frame_byte(b, last);
      bytes_sent++;
      if (last) frames_sent++;
   endtask

   // Sends the first len bytes of the built frame; bytes past its end are random.
   task automatic send_frame(input int len);
      int i;
      for (i = 0; i < len; i++)
         push_byte((i < frame_bytes.size()) ? frame_bytes[i] : 8'($urandom), i == len - 1);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_match(input csr_index_type idx, input logic [15:0] val);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MATCH_ETHERTYPE) cfg_etype = val;
      else cfg_proto = val[7:0];
   endtask

   function automatic frame_fields_t random_fields(input int extra);
      frame_fields_t f;
      int            pick;
      f.dmac  = {16'($urandom), 32'($urandom)};
      f.smac  = {16'($urandom), 32'($urandom)};
      f.etype = cfg_etype;
      f.proto = cfg_proto;
      f.ihl   = ($urandom_range(99) < 60) ? 4'd5 : 4'($urandom_range(5, 15));
      f.sip   = $urandom;
      f.dip   = $urandom;
      f.sport = 16'($urandom);
      f.dport = 16'($urandom);
      f.doff  = ($urandom_range(99) < 80) ? 4'($urandom_range(5, 15))
                                           : 4'($urandom_range(0, 4));
      f.flags = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 45) f.total = 16'(4 * f.ihl + 4 * f.doff + extra);
      else if (pick < 80) f.total = 16'($urandom);
      else f.total = 16'($urandom_range(0, 60));
      return f;
   endfunction

   // Lays out a frame with every header byte in wire order; filler bytes are random.
   task automatic build_frame(input frame_fields_t f, input int extra);
      int lay_ihl, i;
      lay_ihl = (f.ihl < IHL_MIN) ? IHL_MIN : f.ihl;
      frame_bytes.delete();
      for (i = 5; i >= 0; i--) frame_bytes.push_back(f.dmac[8*i +: 8]);
      for (i = 5; i >= 0; i--) frame_bytes.push_back(f.smac[8*i +: 8]);
      frame_bytes.push_back(f.etype[15:8]);
      frame_bytes.push_back(f.etype[7:0]);
      frame_bytes.push_back({4'($urandom), f.ihl});
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(f.total[15:8]);
      frame_bytes.push_back(f.total[7:0]);
      for (i = 0; i < 5; i++) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(f.proto);
      for (i = 0; i < 2; i++) frame_bytes.push_back(8'($urandom));
      for (i = 3; i >= 0; i--) frame_bytes.push_back(f.sip[8*i +: 8]);
      for (i = 3; i >= 0; i--) frame_bytes.push_back(f.dip[8*i +: 8]);
      for (i = 34; i < ETH_HDR_LEN + 4 * lay_ihl; i++) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(f.sport[15:8]);
      frame_bytes.push_back(f.sport[7:0]);
      frame_bytes.push_back(f.dport[15:8]);
      frame_bytes.push_back(f.dport[7:0]);
      for (i = 0; i < 8; i++) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back({f.doff, 4'($urandom)});
      frame_bytes.push_back(f.flags);
      for (i = 0; i < 6 + extra; i++) frame_bytes.push_back(8'($urandom));
   endtask

   task automatic test_field_extremes();
      frame_fields_t f;
      f = '0;
      f.etype = cfg_etype;
      f.proto = cfg_proto;
      f.ihl   = 4'd5;
      f.doff  = 4'd5;
      build_frame(f, 0);
      send_frame(frame_bytes.size());
      f = '1;
      f.etype = cfg_etype;
      f.proto = cfg_proto;
      build_frame(f, 3);
      send_frame(frame_bytes.size());
      // A data offset under five words still counts as given.
      f = random_fields(2);
      f.doff  = 4'd0;
      f.total = 16'd100;
      build_frame(f, 2);
      send_frame(frame_bytes.size());
      // Header lengths larger than the total length leave a payload of zero.
      f = random_fields(4);
      f.total = 16'd10;
      build_frame(f, 4);
      send_frame(frame_bytes.size());
   endtask

   task automatic test_truncated_frames();
      frame_fields_t f;
      int            need, k;
      for (k = 0; k < 2; k++) begin
         f = random_fields(0);
         f.ihl = (k == 0) ? 4'd5 : 4'd15;
         build_frame(f, 0);
         need = ETH_HDR_LEN + 4 * f.ihl + TCP_MIN_LEN;
         send_frame(1);
         send_frame(ETH_HDR_LEN);
         send_frame(ETH_HDR_LEN + 1);
         send_frame(need - 1);
         send_frame(need);
      end
   endtask

   task automatic test_bad_header_length();
      frame_fields_t f;
      f = random_fields(8);
      f.ihl = 4'd4;
      build_frame(f, 8);
      send_frame(frame_bytes.size());
      f = random_fields(8);
      f.ihl = 4'd0;
      build_frame(f, 8);
      send_frame(frame_bytes.size());
      // The next frame starts with a stale header length of zero.
      f = random_fields(1);
      build_frame(f, 1);
      send_frame(frame_bytes.size());
   endtask

   task automatic test_type_mismatch();
      frame_fields_t f;
      f = random_fields(0);
      f.etype = 16'h86DD;
      build_frame(f, 0);
      send_frame(frame_bytes.size());
      f = random_fields(0);
      f.proto = 8'd17;
      build_frame(f, 0);
      send_frame(frame_bytes.size());
   endtask

   task automatic test_match_registers();
      frame_fields_t f;
      int            k;
      for (k = 0; k < 2; k++) begin
         write_match(CSR_MATCH_ETHERTYPE, (k == 0) ? 16'hFFFF : 16'h0000);
         write_match(CSR_MATCH_PROTOCOL, {8'($urandom), (k == 0) ? 8'hFF : 8'h00});
         f = random_fields(1);
         build_frame(f, 1);
         send_frame(frame_bytes.size());
         f.etype = RESET_ETHERTYPE;
         f.proto = RESET_PROTOCOL;
         build_frame(f, 1);
         send_frame(frame_bytes.size());
      end
      write_match(CSR_MATCH_ETHERTYPE, RESET_ETHERTYPE);
      write_match(CSR_MATCH_PROTOCOL, {8'h00, RESET_PROTOCOL});
   endtask

   task automatic test_long_frame();
      frame_fields_t f;
      send_idle_pct = 0;
      f = random_fields(0);
      build_frame(f, 0);
      send_frame(LONG_FRAME_BYTES);
      f = random_fields(0);
      build_frame(f, 0);
      send_frame(frame_bytes.size());
      send_idle_pct = 19;
   endtask

   // The receiver stops for a long stretch while short frames keep coming, so the
   // summary queue fills and the byte input is held back.
   task automatic test_result_backpressure();
      frame_fields_t f;
      settle();
      send_idle_pct = 0;
      stall_requests++;
      repeat (8) begin
         f = random_fields(0);
         build_frame(f, 0);
         send_frame(frame_bytes.size());
      end
      send_idle_pct = 19;
      settle();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      frame_fields_t f;
      int            start_bytes, start_sums, kind, len, extra;
      write_match(CSR_MATCH_ETHERTYPE, 16'($urandom));
      write_match(CSR_MATCH_PROTOCOL, 16'($urandom));
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start_bytes = bytes_sent;
      start_sums  = summaries_expected;
      while (bytes_sent - start_bytes < 180 || summaries_expected - start_sums < 14) begin
         extra = ($urandom_range(99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, 40);
         f = random_fields(extra);
         kind = $urandom_range(99);
         if (kind >= 78 && kind < 84) f.ihl = 4'($urandom_range(0, 4));
         else if (kind >= 84 && kind < 88) f.etype = 16'($urandom);
         else if (kind >= 88 && kind < 92) f.proto = 8'($urandom);
         build_frame(f, extra);
         len = frame_bytes.size();
         if (kind >= 70 && kind < 78) len = $urandom_range(1, len - 1);
         if (kind >= 92) begin
            frame_bytes.delete();
            len = $urandom_range(1, 80);
         end
         send_frame(len);
      end
   endtask

   initial begin : rsp_pacing
      int seen, left, pct;
      seen = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (stall_requests != seen) begin
            seen = stall_requests;
            left = STALL_CYCLES;
         end
         pct = recv_idle_pct;
         @(negedge clock);
         if (left > 0) begin
            rsp_tready <= 1'b0;
            left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= pct);
         end
      end
   end

   initial begin : rsp_check
      logic     hit;
      summary_t got, want;
      forever begin
         @(posedge clock);
         hit = !reset && rsp_tvalid && rsp_tready;
         got = rsp_tdata;
         @(negedge clock);
         if (hit) begin
            if (pending_summaries.size() == 0) begin
               flag_error("result item with no summary expected");
            end else begin
               want = pending_summaries.pop_front();
               compare_field("dst_mac", got.dmac, want.dmac);
               compare_field("src_mac", got.smac, want.smac);
               compare_field("src_ip", got.sip, want.sip);
               compare_field("dst_ip", got.dip, want.dip);
               compare_field("src_port", got.sport, want.sport);
               compare_field("dst_port", got.dport, want.dport);
               compare_field("tcp_flag_bits", got.flags, want.flags);
               compare_field("payload_bytes", got.payload, want.payload);
               summaries_checked++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin : run_tests
      int waited;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_truncated_frames();
      test_bad_header_length();
      test_type_mismatch();
      test_match_registers();
      test_long_frame();
      test_result_backpressure();
      test_random_traffic(19, 85);
      test_random_traffic(85, 19);
      test_random_traffic(0, 0);
      @(negedge clock);
      req_tvalid <= 1'b0;
      for (waited = 0; pending_summaries.size() != 0 && waited < 5000; waited++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_summaries.size() != 0)
         flag_error($sformatf("%0d summaries never arrived", pending_summaries.size()));
      $display("Sent %0d frames (%0d bytes) and checked %0d header summaries.",
               frames_sent, bytes_sent, summaries_checked);
      $display("Runs covered short, bad and mismatched frames, a 64k+ frame and a long stall.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
